// ===== src/rcrc8_pkg.sv =====
// Package for the reflected CRC-8 message block: message length, mask reset
// value and the byte-wide CRC update function. No dependencies.
`timescale 1ns / 1ps

package rcrc8_pkg;

  // bytes per message and the width of the byte counter
  localparam int unsigned MessageBytes = 4;
  localparam int unsigned CountW = (MessageBytes > 1) ? $clog2(MessageBytes) : 1;

  // feedback mask after reset
  localparam logic [7:0] MaskReset = 8'h9E;

  typedef logic [CountW-1:0] count_t;

  // eight reflected bit steps, data taken lsb first
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in,
                                          input logic [7:0] data,
                                          input logic [7:0] mask);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = data[k] ^ crc[0];
      crc = (crc ^ (fb ? mask : 8'h00)) >> 1;
      crc[7] = fb;
    end
    return crc;
  endfunction

endpackage

// ===== src/reflected_crc8_message.sv =====
// Top level of the reflected CRC-8 message block: input register, byte-wide
// CRC update and result register. Depends on rcrc8_pkg.
`timescale 1ns / 1ps

// Takes one message byte per cycle on the slave stream unless stalled and,
// after every rcrc8_pkg::MessageBytes-th byte, sends the 8-bit reflected CRC
// of that message on the master stream; the CRC restarts from zero for the
// next message. A byte is held in the input register, then the eight bit
// steps run as one xor network into the running CRC and, for the last byte,
// into the result register; the sustained rate is one byte per cycle while
// no finished CRC is held up. Back pressure on the master side stalls the
// input only when a finished CRC cannot move out. The feedback mask is
// written through cfg_we_i and cfg_wdata_i, by the user only while the block
// is idle (the block itself does not enforce this); it resets to 0x9E.
module reflected_crc8_message (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,   // feedback_mask
  // byte stream in
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  // crc stream out
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [7:0] crc_value
);

  logic                 mask_q;
  logic [7:0]           fb_mask_q;
  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic [7:0]           crc_q;
  logic [7:0]           crc_next;
  rcrc8_pkg::count_t    count_q;
  logic                 in_last;
  logic                 out_free;
  logic                 in_adv;
  logic                 in_fire;
  logic                 out_valid_q;
  logic [7:0]           out_crc_q;

  // feedback mask register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_mask_q <= rcrc8_pkg::MaskReset;
      mask_q    <= 1'b0;
    end else if (cfg_we_i) begin
      fb_mask_q <= cfg_wdata_i;
      mask_q    <= 1'b1;
    end
  end

  // handshake between the stages
  assign in_last  = (count_q == rcrc8_pkg::count_t'(rcrc8_pkg::MessageBytes - 1));
  assign out_free = !out_valid_q || m_axis_tready;
  assign in_adv   = in_valid_q && (!in_last || out_free);
  assign s_axis_tready = !in_valid_q || in_adv;
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // byte-wide crc update
  assign crc_next = rcrc8_pkg::crc_byte(crc_q, in_byte_q, fb_mask_q);

  // running crc and byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= 8'h00;
      count_q <= '0;
    end else if (in_adv) begin
      if (in_last) begin
        crc_q   <= 8'h00;
        count_q <= '0;
      end else begin
        crc_q   <= crc_next;
        count_q <= count_q + rcrc8_pkg::count_t'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_adv && in_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_last) begin
      out_crc_q <= crc_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_crc_q;

  // the last byte of a message leaves the running state cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && in_last) |=> (crc_q == 8'h00 && count_q == '0))
    else $error("running crc not cleared after last byte");

  // a new result only follows a last byte that moved on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready))
      |-> $past(in_adv && in_last))
    else $error("result without a completed message");

  // the input stage only stalls while it holds a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && in_last && out_valid_q))
    else $error("input stalled without a blocked result");

  // mask write flag is kept only for visibility of the first write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (mask_q && fb_mask_q == $past(cfg_wdata_i)))
    else $error("feedback mask write lost");

endmodule

// ===== test/tb.sv =====
// Testbench for reflected_crc8_message: directed table, then random messages under
// fixed and random mask settings, each crc checked against an in-bench model or a hand-worked value.
// Depends on rcrc8_pkg and the reflected_crc8_message top level.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles   = 8;
  localparam int unsigned RandomPhases = 9;
  localparam int unsigned CalmStart    = 600;
  localparam int unsigned CalmEnd      = 900;
  localparam int unsigned NumRows      = 27;

  typedef enum logic {ROW_BYTE, ROW_MASK} row_kind_e;

  // one row: a message byte or a mask write; known_crc holds a hand-worked crc
  typedef struct packed {
    row_kind_e  kind;
    logic [7:0] value;
    logic       known;
    logic [7:0] known_crc;
  } row_t;

  localparam row_t DirectedRows [NumRows] = '{
    // reset mask, all-zero message keeps the crc at zero
    '{ROW_BYTE, 8'h00, 1'b0, 8'h00}, '{ROW_BYTE, 8'h00, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h00, 1'b0, 8'h00}, '{ROW_BYTE, 8'h00, 1'b1, 8'h00},
    // reset mask, all-ones and single set bits
    '{ROW_BYTE, 8'hFF, 1'b0, 8'h00}, '{ROW_BYTE, 8'hFF, 1'b0, 8'h00},
    '{ROW_BYTE, 8'hFF, 1'b0, 8'h00}, '{ROW_BYTE, 8'hFF, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h01, 1'b0, 8'h00}, '{ROW_BYTE, 8'h80, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h55, 1'b0, 8'h00}, '{ROW_BYTE, 8'hAA, 1'b0, 8'h00},
    // zero mask turns the crc into the xor of the message bytes
    '{ROW_MASK, 8'h00, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h12, 1'b0, 8'h00}, '{ROW_BYTE, 8'h34, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h56, 1'b0, 8'h00}, '{ROW_BYTE, 8'h78, 1'b1, 8'h08},
    '{ROW_BYTE, 8'hFF, 1'b0, 8'h00}, '{ROW_BYTE, 8'h00, 1'b0, 8'h00},
    '{ROW_BYTE, 8'hFF, 1'b0, 8'h00}, '{ROW_BYTE, 8'h00, 1'b1, 8'h00},
    // full mask, then a mask change in the middle of a message
    '{ROW_MASK, 8'hFF, 1'b0, 8'h00},
    '{ROW_BYTE, 8'hA5, 1'b0, 8'h00}, '{ROW_BYTE, 8'h5A, 1'b0, 8'h00},
    '{ROW_MASK, 8'h01, 1'b0, 8'h00},
    '{ROW_BYTE, 8'h3C, 1'b0, 8'h00}, '{ROW_BYTE, 8'hC3, 1'b0, 8'h00}
  };

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [7:0] cfg_wdata_i   = 8'h00;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  // model state and the crcs still owed by the block
  logic [7:0] poly_mask    = rcrc8_pkg::MaskReset;
  logic [7:0] msg_crc      = 8'h00;
  int         bytes_in_msg = 0;
  logic [7:0] pending_crcs [$];

  int   err_count   = 0;
  int   quiet_count = 0;
  int   cycle_count = 0;
  logic calm        = 1'b0;

  reflected_crc8_message dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // reflected crc over one byte, lsb first
  function automatic logic [7:0] fold_byte(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] mask);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      fb = acc[0] ^ data[i];
      if (fb) acc = acc ^ mask;
      acc = {fb, acc[7:1]};
    end
    return acc;
  endfunction

  // advance the model by one accepted byte, queue the crc at message end
  task automatic take_byte(input logic [7:0] data, input logic known,
                           input logic [7:0] known_crc);
    msg_crc = fold_byte(msg_crc, data, poly_mask);
    bytes_in_msg++;
    if (bytes_in_msg >= rcrc8_pkg::MessageBytes) begin
      pending_crcs.push_back(known ? known_crc : msg_crc);
      msg_crc      = 8'h00;
      bytes_in_msg = 0;
    end
  endtask

  // one byte transfer with random gaps in front
  task automatic send_byte(input logic [7:0] data, input logic known,
                           input logic [7:0] known_crc);
    while (!calm && $urandom_range(0, 99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    take_byte(data, known, known_crc);
  endtask

  // hold the input until every crc is out and the pipe is empty, then write the mask
  task automatic write_mask(input logic [7:0] mask);
    s_axis_tvalid <= 1'b0;
    while (pending_crcs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mask;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    poly_mask = mask;
  endtask

  // calm window: neither side idles
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    calm        <= (cycle_count >= CalmStart) && (cycle_count < CalmEnd);
  end

  // receiver back pressure
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 21);
  end

  // crc checker
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_crcs.size() == 0) begin
        $display("%0t: unexpected crc transfer, expected none, got %02h",
                 $time, m_axis_tdata);
        err_count++;
      end else begin
        want = pending_crcs.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: crc_value mismatch, expected %02h, got %02h",
                   $time, want, m_axis_tdata);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_count <= 0;
    end else if (quiet_count >= StallLimit) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // stimulus
  initial begin
    logic [7:0] mask;
    logic [7:0] data;
    int         n_bytes;
    int         pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < NumRows; r++) begin
      if (DirectedRows[r].kind == ROW_MASK) begin
        write_mask(DirectedRows[r].value);
      end else begin
        send_byte(DirectedRows[r].value, DirectedRows[r].known, DirectedRows[r].known_crc);
      end
    end

    // random phases; phase lengths land the mask writes mid-message too
    for (int p = 0; p < RandomPhases; p++) begin
      unique case (p)
        0: begin
          mask = 8'hFF;
        end
        1: begin
          mask = 8'h00;
        end
        2: begin
          mask = rcrc8_pkg::MaskReset;
        end
        default: begin
          mask = 8'($urandom_range(0, 255));
        end
      endcase
      write_mask(mask);
      n_bytes = $urandom_range(90, 110);
      repeat (n_bytes) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) data = 8'h00;
        else if (pick == 1) data = 8'hFF;
        else data = 8'($urandom_range(0, 255));
        send_byte(data, 1'b0, 8'h00);
      end
    end

    // drain and finish
    s_axis_tvalid <= 1'b0;
    while (pending_crcs.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
